// File: sv/median_filter_3x3_rgb_top_macros.svh
`ifndef MEDIAN_FILTER_3X3_RGB_TOP_MACROS_SVH
`define MEDIAN_FILTER_3X3_RGB_TOP_MACROS_SVH

// same-cycle implication on clk_i, off while rst_ni is low
`define MF3_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication on clk_i, off while rst_ni is low
`define MF3_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/mf3rgb_pkg.sv
package mf3rgb_pkg;

  // field and register widths
  localparam int CH_W    = 8;
  localparam int OUT_CH  = 3;
  localparam int FW_W    = 11;
  localparam int FH_W    = 16;
  localparam int CFG_A_W = 1;
  localparam int CFG_D_W = 16;

  // smallest usable frame dimension
  localparam int MIN_DIM = 3;

  // register reset values
  localparam logic [FW_W-1:0] RST_FRAME_WIDTH  = 11'd640;
  localparam logic [FH_W-1:0] RST_FRAME_HEIGHT = 16'd480;

  // register indexes
  localparam logic [CFG_A_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_A_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  // item modes
  localparam logic MODE_PIXEL = 1'b0;
  localparam logic MODE_FLUSH = 1'b1;

  typedef logic [CH_W-1:0] chan_t;

  // divider status toward the top level
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// File: sv/mf3rgb_ram.sv
module mf3rgb_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// File: sv/mf3rgb_median.sv
module mf3rgb_median
  import mf3rgb_pkg::*;
(
  input  chan_t [8:0] win_i,
  output chan_t       med_o
);

  function automatic chan_t fmin(chan_t a, chan_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic chan_t fmax(chan_t a, chan_t b);
    return (a < b) ? b : a;
  endfunction

  function automatic chan_t fmed3(chan_t a, chan_t b, chan_t c);
    return fmax(fmin(a, b), fmin(fmax(a, b), c));
  endfunction

  chan_t [2:0] lo;
  chan_t [2:0] mi;
  chan_t [2:0] hi;

  // sort each row, then median of max-of-lows, median-of-mids, min-of-highs
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      lo[i] = fmin(fmin(win_i[3*i], win_i[3*i+1]), win_i[3*i+2]);
      mi[i] = fmed3(win_i[3*i], win_i[3*i+1], win_i[3*i+2]);
      hi[i] = fmax(fmax(win_i[3*i], win_i[3*i+1]), win_i[3*i+2]);
    end
    med_o = fmed3(fmax(fmax(lo[0], lo[1]), lo[2]),
                  fmed3(mi[0], mi[1], mi[2]),
                  fmin(fmin(hi[0], hi[1]), hi[2]));
  end

endmodule

// File: sv/mf3rgb_div.sv
module mf3rgb_div
  import mf3rgb_pkg::*;
#(
  parameter int DVD_W = 26,
  parameter int DVS_W = 11
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  output logic [DVD_W-1:0] quot_o,
  output logic [DVS_W-1:0] rem_o,
  output div_stat_t        stat_o
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] quot_q, quot_d;
  logic [DVS_W-1:0] rem_q, rem_d;
  logic [DVS_W-1:0] dvs_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic             done_q;
  logic [DVS_W:0]   trial;

  // one restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    trial = {rem_q, quot_q[DVD_W-1]};
    if (trial >= {1'b0, dvs_q}) begin
      rem_d  = DVS_W'(trial - {1'b0, dvs_q});
      quot_d = {quot_q[DVD_W-2:0], 1'b1};
    end else begin
      rem_d  = DVS_W'(trial);
      quot_d = {quot_q[DVD_W-2:0], 1'b0};
    end
  end

  // control, a new start restarts the run
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(DVD_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= dividend_i;
      rem_q  <= '0;
      dvs_q  <= divisor_i;
    end else if (busy_q) begin
      quot_q <= quot_d;
      rem_q  <= rem_d;
    end
  end

  assign quot_o      = quot_q;
  assign rem_o       = rem_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

// File: sv/median_filter_3x3_rgb_top.sv
// an item's result passes the line store read and the second-stage registers, then the result register
// throughput: one item per cycle while the output is not stalled and no width change is pending; line store
//   read is prefetched at transfer and written back from the second stage with a write-to-read bypass
// a frame_width write holds off input while a serial divider recomputes the output row and column
// reset: rst_ni asynchronous, active low, clears counters, window and handshake state; line stores keep contents
`include "median_filter_3x3_rgb_top_macros.svh"

module median_filter_3x3_rgb_top
  import mf3rgb_pkg::*;
#(
  parameter int MAX_WIDTH = 1024,
  parameter int CHANNELS  = 3
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CFG_A_W-1:0] cfg_addr_i,
  input  logic [CFG_D_W-1:0] cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               mode_i,
  input  chan_t              in_ch0_i,
  input  chan_t              in_ch1_i,
  input  chan_t              in_ch2_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output chan_t              out_ch0_o,
  output chan_t              out_ch1_o,
  output chan_t              out_ch2_o,
  output logic               out_frame_end_o
);

  localparam int FW_MAX = (1 << FW_W) - 1;
  localparam int WMAX   = (MAX_WIDTH < FW_MAX) ? MAX_WIDTH : FW_MAX;
  localparam int NCH    = (CHANNELS < OUT_CH) ? CHANNELS : OUT_CH;
  localparam int PIX_W  = NCH * CH_W;
  localparam int COL_W  = $clog2(WMAX);
  localparam int EW_W   = $clog2(WMAX + 1);
  localparam int POS_W  = $clog2(WMAX * ((1 << FH_W) - 1) + 1);

  typedef enum logic [1:0] {
    SRC_CENTRE,
    SRC_MEDIAN,
    SRC_UPPER,
    SRC_LOWER
  } src_e;

  // configuration
  logic [FW_W-1:0] frame_width_q;
  logic [FH_W-1:0] frame_height_q;
  logic            div_req_q;
  logic            cfg_wr_width;
  logic [EW_W-1:0] eff_w;
  logic [FH_W-1:0] eff_h;

  // counters
  logic [COL_W-1:0] in_col_q, in_col_d;
  logic [FH_W-1:0]  in_row_q, in_row_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic [POS_W-1:0] r_q, r_d;
  logic [COL_W-1:0] c_q, c_d;

  // transfer stage decode
  logic             in_fire;
  logic             col_wrap;
  logic [COL_W-1:0] col_s;
  logic [FH_W-1:0]  row_s;
  logic [COL_W:0]   col_inc;
  logic             is_flush;
  logic             rows_done;
  logic             c_last;
  logic             r_last;
  logic             frame_end;
  logic             border;
  logic             pix_go;
  logic             early;
  logic             produce;
  src_e             src;
  logic [COL_W-1:0] raddr;
  logic [PIX_W-1:0] pix_in;
  logic [OUT_CH*CH_W-1:0] in_all;

  // divider
  logic [POS_W-1:0] div_quot;
  logic [EW_W-1:0]  div_rem;
  div_stat_t        div_stat;
  logic             div_active;

  // second stage
  logic             s1_valid_q;
  logic             s1_wr_q;
  logic             s1_out_q;
  logic             s1_fire;
  src_e             s1_src_q;
  logic             s1_end_q;
  logic [COL_W-1:0] s1_col_q;
  logic [PIX_W-1:0] s1_pix_q;
  logic             byp_q;
  logic [2*PIX_W-1:0] byp_data_q;
  logic [2*PIX_W-1:0] ram_rdata;
  logic [2*PIX_W-1:0] mem_word;
  logic [2*PIX_W-1:0] ram_wdata;
  logic [PIX_W-1:0]   st_upper;
  logic [PIX_W-1:0]   st_lower;
  logic [2:0][2:0][PIX_W-1:0] win_q, win_n;
  wire  [PIX_W-1:0]   med_pix;
  logic [PIX_W-1:0]   res_d;

  // result register
  logic             res_valid_q;
  logic [PIX_W-1:0] res_q;
  logic             res_end_q;
  logic [OUT_CH*CH_W-1:0] res_ext;

  // register writes
  assign cfg_wr_width = cfg_we_i && (cfg_addr_i == REG_FRAME_WIDTH);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= RST_FRAME_WIDTH;
      frame_height_q <= RST_FRAME_HEIGHT;
      div_req_q      <= 1'b0;
    end else begin
      div_req_q <= 1'b0;
      if (cfg_we_i) begin
        unique case (cfg_addr_i)
          REG_FRAME_WIDTH: begin
            frame_width_q <= cfg_wdata_i[FW_W-1:0];
            div_req_q     <= 1'b1;
          end
          REG_FRAME_HEIGHT: frame_height_q <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  // saturated frame dimensions
  always_comb begin
    if (frame_width_q < FW_W'(MIN_DIM)) begin
      eff_w = EW_W'(MIN_DIM);
    end else if (32'(frame_width_q) > WMAX) begin
      eff_w = EW_W'(WMAX);
    end else begin
      eff_w = EW_W'(frame_width_q);
    end
    eff_h = (frame_height_q < FH_W'(MIN_DIM)) ? FH_W'(MIN_DIM) : frame_height_q;
  end

  // output row and column recompute after a width change
  mf3rgb_div #(
    .DVD_W(POS_W),
    .DVS_W(EW_W)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_req_q),
    .dividend_i(pos_q),
    .divisor_i (eff_w),
    .quot_o    (div_quot),
    .rem_o     (div_rem),
    .stat_o    (div_stat)
  );

  assign div_active = div_req_q || div_stat.busy || div_stat.done;

  // handshake
  assign s1_fire    = s1_valid_q && (!s1_out_q || !res_valid_q || out_ready_i);
  assign in_ready_o = (!s1_valid_q || s1_fire) && !div_active && !cfg_wr_width;
  assign in_fire    = in_valid_i && in_ready_o;

  assign in_all = {in_ch2_i, in_ch1_i, in_ch0_i};
  assign pix_in = in_all[PIX_W-1:0];

  // item decode against the current counters
  always_comb begin
    col_wrap  = 32'(in_col_q) >= 32'(eff_w);
    col_s     = col_wrap ? '0 : in_col_q;
    row_s     = col_wrap ? in_row_q + FH_W'(1) : in_row_q;
    col_inc   = {1'b0, col_s} + (COL_W+1)'(1);
    is_flush  = (mode_i == MODE_FLUSH);
    rows_done = row_s >= eff_h;
    c_last    = (32'(c_q) + 32'd1) == 32'(eff_w);
    r_last    = (32'(r_q) + 32'd1) >= 32'(eff_h);
    frame_end = (32'(r_q) >= 32'(eff_h))
                || (((32'(r_q) + 32'd1) == 32'(eff_h)) && c_last);
    border    = (r_q == '0) || r_last || (c_q == '0) || c_last;
    pix_go    = !is_flush && !rows_done;
    early     = (row_s == '0) || ((row_s == FH_W'(1)) && (col_s == '0));
    produce   = is_flush ? rows_done : (pix_go && !early);
    if (is_flush) begin
      src = (c_last && !r_last) ? SRC_UPPER : SRC_LOWER;
    end else begin
      src = border ? SRC_CENTRE : SRC_MEDIAN;
    end
    raddr = is_flush ? c_q : col_s;
  end

  // counter next state
  always_comb begin
    in_col_d = in_col_q;
    in_row_d = in_row_q;
    pos_d    = pos_q;
    r_d      = r_q;
    c_d      = c_q;
    if (in_fire) begin
      in_col_d = col_s;
      in_row_d = row_s;
      if (pix_go) begin
        if (32'(col_inc) >= 32'(eff_w)) begin
          in_col_d = '0;
          in_row_d = row_s + FH_W'(1);
        end else begin
          in_col_d = col_inc[COL_W-1:0];
        end
      end
      if (produce) begin
        if (frame_end) begin
          in_col_d = '0;
          in_row_d = '0;
          pos_d    = '0;
          r_d      = '0;
          c_d      = '0;
        end else begin
          pos_d = pos_q + POS_W'(1);
          if (c_last) begin
            c_d = '0;
            r_d = r_q + POS_W'(1);
          end else begin
            c_d = c_q + COL_W'(1);
          end
        end
      end
    end
    if (div_stat.done) begin
      r_d = div_quot;
      c_d = COL_W'(div_rem);
    end
  end

  // line stores, upper and lower row share one address
  mf3rgb_ram #(
    .WIDTH(2 * PIX_W),
    .DEPTH(WMAX)
  ) u_lines (
    .clk_i  (clk_i),
    .we_i   (s1_fire && s1_wr_q),
    .waddr_i(s1_col_q),
    .wdata_i(ram_wdata),
    .re_i   (in_fire),
    .raddr_i(raddr),
    .rdata_o(ram_rdata)
  );

  // store word with write-to-read bypass
  assign mem_word  = byp_q ? byp_data_q : ram_rdata;
  assign st_upper  = mem_word[2*PIX_W-1:PIX_W];
  assign st_lower  = mem_word[PIX_W-1:0];
  assign ram_wdata = {st_lower, s1_pix_q};

  // window after the shift
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      win_n[i][0] = win_q[i][1];
      win_n[i][1] = win_q[i][2];
    end
    win_n[0][2] = st_upper;
    win_n[1][2] = st_lower;
    win_n[2][2] = s1_pix_q;
  end

  // one median network per channel
  for (genvar k = 0; k < NCH; k++) begin : g_lane
    chan_t [8:0] taps;
    always_comb begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          taps[3*i+j] = win_n[i][j][k*CH_W +: CH_W];
        end
      end
    end
    mf3rgb_median u_med (
      .win_i(taps),
      .med_o(med_pix[k*CH_W +: CH_W])
    );
  end

  // result select
  always_comb begin
    res_d = win_n[1][1];
    case (s1_src_q)
      SRC_CENTRE: res_d = win_n[1][1];
      SRC_MEDIAN: res_d = med_pix;
      SRC_UPPER:  res_d = st_upper;
      SRC_LOWER:  res_d = st_lower;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q    <= '0;
      in_row_q    <= '0;
      pos_q       <= '0;
      r_q         <= '0;
      c_q         <= '0;
      s1_valid_q  <= 1'b0;
      s1_wr_q     <= 1'b0;
      s1_out_q    <= 1'b0;
      byp_q       <= 1'b0;
      res_valid_q <= 1'b0;
      win_q       <= '0;
    end else begin
      in_col_q <= in_col_d;
      in_row_q <= in_row_d;
      pos_q    <= pos_d;
      r_q      <= r_d;
      c_q      <= c_d;
      if (in_fire) begin
        s1_valid_q <= pix_go || produce;
        s1_wr_q    <= pix_go;
        s1_out_q   <= produce;
        byp_q      <= s1_fire && s1_wr_q && (s1_col_q == raddr);
      end else if (s1_fire) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_fire && s1_wr_q) begin
        win_q <= win_n;
      end
      if (s1_fire && s1_out_q) begin
        res_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_src_q   <= src;
      s1_end_q   <= frame_end;
      s1_col_q   <= col_s;
      s1_pix_q   <= pix_in;
      byp_data_q <= ram_wdata;
    end
    if (s1_fire && s1_out_q) begin
      res_q     <= res_d;
      res_end_q <= s1_end_q;
    end
  end

  // outputs, channels beyond the stored ones read zero
  assign res_ext         = (OUT_CH*CH_W)'(res_q);
  assign out_valid_o     = res_valid_q;
  assign out_ch0_o       = res_ext[0*CH_W +: CH_W];
  assign out_ch1_o       = res_ext[1*CH_W +: CH_W];
  assign out_ch2_o       = res_ext[2*CH_W +: CH_W];
  assign out_frame_end_o = res_end_q;

  // checks
  `MF3_ASSERT_NOW(a_no_take_in_recompute, div_active, !in_ready_o,
                  "input transfer while output row and column are recomputed")
  `MF3_ASSERT_NOW(a_out_col_in_range, !div_active, 32'(c_q) < 32'(eff_w),
                  "output column at or beyond frame width")
  `MF3_ASSERT_NEXT(a_frame_end_clears, in_fire && produce && frame_end,
                   (pos_q == '0) && (in_row_q == '0) && (in_col_q == '0),
                   "counters not cleared after last output of a frame")

endmodule
